// ----- sv/aphd_pkg.sv -----
`default_nettype none

package aphd_pkg;

    // Fixed field widths of the register file and result beat
    localparam int CFG_W       = 16;
    localparam int FACTOR_W    = 17;
    localparam int AVG_W       = 8;
    localparam int ADDR_W      = 5;
    localparam int APB_DATA_W  = 32;
    localparam int SLOPE_SHIFT = 14;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_AVERAGE_DEF = 255;

    // Register reset values
    localparam logic [CFG_W-1:0]    ADC_FULL_RST    = 16'd4095;
    localparam logic [CFG_W-1:0]    FULL_SCALE_RST  = 16'd3300;
    localparam logic [CFG_W-1:0]    POLL_RST        = 16'd0;
    localparam logic [CFG_W-1:0]    HOLD_RST        = 16'd0;
    localparam logic [FACTOR_W-1:0] DECAY_RST       = 17'h10000;
    localparam logic [AVG_W-1:0]    AVG_COUNT_RST   = 8'd0;
    localparam logic [CFG_W-1:0]    SLOPE_RST       = 16'd16384;
    localparam logic [CFG_W-1:0]    ZERO_OFFSET_RST = 16'd0;

    typedef enum logic [2:0] {
        REG_ADC_FULL    = 3'd0,
        REG_FULL_SCALE  = 3'd1,
        REG_POLL        = 3'd2,
        REG_HOLD        = 3'd3,
        REG_DECAY       = 3'd4,
        REG_AVG_COUNT   = 3'd5,
        REG_SLOPE       = 3'd6,
        REG_ZERO_OFFSET = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]    adc_full_count;
        logic [CFG_W-1:0]    full_scale_mv;
        logic [CFG_W-1:0]    poll_interval_ms;
        logic [CFG_W-1:0]    hold_interval_ms;
        logic [FACTOR_W-1:0] decay_factor;
        logic [AVG_W-1:0]    average_count;
        logic [CFG_W-1:0]    slope_gain;
        logic [CFG_W-1:0]    zero_offset_mv;
    } cfg_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_DECAY,
        ST_SAMPLE,
        ST_CHECK,
        ST_AVG,
        ST_MAP,
        ST_DIV,
        ST_SLOPE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- sv/adc_average_peak_hold_decay_unit.sv -----
`default_nettype none

// Channel   Direction  Ports                        Contents
// s_        in         s_tvalid/s_tready/s_tdata    tdata: adc_sample; tuser: ms_tick, sample_valid
// m_        out        m_tvalid/m_tready/m_tdata    tdata: level_mv, peak_mv, peak_raw
// config    in/out     psel/penable/pwrite/paddr    eight registers at byte address 4*i
//
// A beat is accepted only in the idle state; the next beat waits until the last is done.
// A tick-driven decay step uses the shared multiplier; a closing sample runs
// divide, multiply, divide, multiply, then commit.
// All multiplies and divides go through one shift/add unit.
// Reset is synchronous on aresetn and clears all counters, peaks and the result slot.
// A held result beat does not block intake; only a second result waits for the slot.
module adc_average_peak_hold_decay_unit
    import aphd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_AVERAGE = MAX_AVERAGE_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    // input beats
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,  // adc_sample
    input  wire logic [1:0]                                s_tuser,  // ms_tick, sample_valid
    // result beats
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    output logic      [((2*CFG_W+SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,  // level_mv, peak_mv, peak_raw
    // configuration
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [ADDR_W-1:0]                         paddr,
    input  wire logic [APB_DATA_W-1:0]                     pwdata,
    output logic      [APB_DATA_W-1:0]                     prdata,
    output logic                                           pready
);

    localparam int SB       = SAMPLE_BITS;
    localparam int SUM_W    = SB + AVG_W;
    localparam int DIVN     = SB + CFG_W;
    localparam int W        = SB + 2*CFG_W;
    localparam int SCL_W    = W - SLOPE_SHIFT;
    localparam int M_DATA_W = ((2*CFG_W+SB+7)/8)*8;

    cfg_t cfg;

    aphd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    unit_req_t        u_req;
    unit_sts_t        u_sts;
    logic [W-1:0]     u_opa;
    logic [CFG_W-1:0] u_opb;
    logic [W-1:0]     u_result;

    aphd_arith_unit #(
        .W    (W),
        .DIVN (DIVN)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (u_req),
        .opa     (u_opa),
        .opb     (u_opb),
        .sts     (u_sts),
        .result  (u_result)
    );

    // Sequencer and measurement state
    state_t           state_reg, state_next;
    logic [CFG_W-1:0] poll_elapsed_reg, poll_elapsed_next;
    logic [CFG_W-1:0] hold_elapsed_reg, hold_elapsed_next;
    logic             measuring_reg, measuring_next;
    logic [SUM_W-1:0] sample_sum_reg, sample_sum_next;
    logic [AVG_W-1:0] samples_taken_reg, samples_taken_next;
    logic [SB-1:0]    raw_peak_reg, raw_peak_next;
    logic [CFG_W-1:0] mapped_peak_reg, mapped_peak_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Beat and result payload
    logic             tick_reg, tick_next;
    logic             valid_reg, valid_next;
    logic [SB-1:0]    sample_reg, sample_next;
    logic [SB-1:0]    avg_reg, avg_next;
    logic [CFG_W-1:0] level_reg, level_next;
    logic [CFG_W-1:0] m_level_reg, m_level_next;
    logic [CFG_W-1:0] m_peak_mv_reg, m_peak_mv_next;
    logic [SB-1:0]    m_peak_raw_reg, m_peak_raw_next;

    logic             in_beat;
    logic             out_free;
    logic [CFG_W-1:0] hold_inc;
    logic [CFG_W-1:0] poll_inc;
    logic             decay_due;
    logic             decay_mul;
    logic             arm_due;
    logic             take_sample;
    logic [AVG_W-1:0] target;
    logic             count_reached;
    logic [CFG_W-1:0] map_div;
    logic [SCL_W-1:0] scaled;
    logic [SCL_W-1:0] offset_ext;
    logic [SCL_W-1:0] diff;
    logic [CFG_W-1:0] level_calc;
    logic             peak_take;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_peak_raw_reg, m_peak_mv_reg, m_level_reg});

    // Saturating millisecond counters; intervals 0 and 1 both fire on every tick (poll only outside a measurement)
    assign hold_inc  = (hold_elapsed_reg == '1) ? hold_elapsed_reg
                                                : hold_elapsed_reg + CFG_W'(1);
    assign poll_inc  = (poll_elapsed_reg == '1) ? poll_elapsed_reg
                                                : poll_elapsed_reg + CFG_W'(1);
    assign decay_due = tick_reg && (hold_inc >= cfg.hold_interval_ms);
    // Zero factor clears outright, unity or above leaves the peak alone
    assign decay_mul = decay_due && (cfg.decay_factor != '0)
                       && !cfg.decay_factor[FACTOR_W-1];
    assign arm_due   = tick_reg && !measuring_reg && (poll_inc >= cfg.poll_interval_ms);

    assign take_sample = valid_reg && measuring_reg;

    // Samples per measurement: zero acts as one, clamp to MAX_AVERAGE
    always_comb begin
        target = (cfg.average_count == '0) ? AVG_W'(1) : cfg.average_count;
        if (int'(target) > MAX_AVERAGE) begin
            target = AVG_W'(MAX_AVERAGE);
        end
    end
    assign count_reached = (samples_taken_reg >= target);

    assign map_div = (cfg.adc_full_count == '0) ? CFG_W'(1) : cfg.adc_full_count;

    // Slope result: drop the Q2.14 fraction, subtract offset with clamp, saturate
    assign scaled     = u_result[W-1:SLOPE_SHIFT];
    assign offset_ext = SCL_W'(cfg.zero_offset_mv);
    assign diff       = (scaled >= offset_ext) ? scaled - offset_ext : '0;
    assign level_calc = (diff > SCL_W'({CFG_W{1'b1}})) ? {CFG_W{1'b1}} : diff[CFG_W-1:0];

    assign peak_take = (avg_reg >= raw_peak_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_beat) state_next = ST_TICK;
            ST_TICK:   state_next = decay_mul ? ST_DECAY : ST_SAMPLE;
            ST_DECAY:  if (u_sts.done) state_next = ST_SAMPLE;
            ST_SAMPLE: state_next = take_sample ? ST_CHECK : ST_IDLE;
            ST_CHECK:  state_next = count_reached ? ST_AVG : ST_IDLE;
            ST_AVG:    if (u_sts.done) state_next = ST_MAP;
            ST_MAP:    if (u_sts.done) state_next = ST_DIV;
            ST_DIV:    if (u_sts.done) state_next = ST_SLOPE;
            ST_SLOPE:  if (u_sts.done) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath control per state
    always_comb begin
        poll_elapsed_next  = poll_elapsed_reg;
        hold_elapsed_next  = hold_elapsed_reg;
        measuring_next     = measuring_reg;
        sample_sum_next    = sample_sum_reg;
        samples_taken_next = samples_taken_reg;
        raw_peak_next      = raw_peak_reg;
        mapped_peak_next   = mapped_peak_reg;
        tick_next          = tick_reg;
        valid_next         = valid_reg;
        sample_next        = sample_reg;
        avg_next           = avg_reg;
        level_next         = level_reg;
        m_level_next       = m_level_reg;
        m_peak_mv_next     = m_peak_mv_reg;
        m_peak_raw_next    = m_peak_raw_reg;
        m_tvalid_next      = m_tready ? 1'b0 : m_tvalid_reg;
        u_req.start        = 1'b0;
        u_req.op           = OP_MUL;
        u_opa              = '0;
        u_opb              = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    tick_next   = s_tuser[0];
                    valid_next  = s_tuser[1];
                    sample_next = s_tdata[SB-1:0];
                end
            end
            ST_TICK: begin
                if (tick_reg) begin
                    hold_elapsed_next = decay_due ? '0 : hold_inc;
                    if (!measuring_reg) begin
                        poll_elapsed_next = arm_due ? '0 : poll_inc;
                    end
                end
                if (decay_due && cfg.decay_factor == '0) begin
                    raw_peak_next = '0;
                end
                if (decay_mul) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_opa       = W'(raw_peak_reg);
                    u_opb       = cfg.decay_factor[CFG_W-1:0];
                end
                if (arm_due) begin
                    measuring_next     = 1'b1;
                    sample_sum_next    = '0;
                    samples_taken_next = '0;
                end
            end
            ST_DECAY: begin
                if (u_sts.done) begin
                    raw_peak_next = u_result[SB+CFG_W-1:CFG_W];
                end
            end
            ST_SAMPLE: begin
                if (take_sample) begin
                    sample_sum_next    = sample_sum_reg + SUM_W'(sample_reg);
                    samples_taken_next = samples_taken_reg + AVG_W'(1);
                end
            end
            ST_CHECK: begin
                if (count_reached) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_opa       = W'(sample_sum_reg);
                    u_opb       = CFG_W'(samples_taken_reg);
                end
            end
            ST_AVG: begin
                // average done: scale it by full-scale millivolts
                if (u_sts.done) begin
                    avg_next    = u_result[SB-1:0];
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_opa       = W'(u_result[SB-1:0]);
                    u_opb       = cfg.full_scale_mv;
                end
            end
            ST_MAP: begin
                if (u_sts.done) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_DIV;
                    u_opa       = u_result;
                    u_opb       = map_div;
                end
            end
            ST_DIV: begin
                if (u_sts.done) begin
                    u_req.start = 1'b1;
                    u_req.op    = OP_MUL;
                    u_opa       = u_result;
                    u_opb       = cfg.slope_gain;
                end
            end
            ST_SLOPE: begin
                if (u_sts.done) begin
                    level_next = level_calc;
                end
            end
            ST_OUT: begin
                // wait for the result slot, then commit the peak and close the measurement
                if (out_free) begin
                    if (peak_take) begin
                        raw_peak_next    = avg_reg;
                        mapped_peak_next = level_reg;
                    end
                    measuring_next     = 1'b0;
                    sample_sum_next    = '0;
                    samples_taken_next = '0;
                    m_level_next       = level_reg;
                    m_peak_mv_next     = peak_take ? level_reg : mapped_peak_reg;
                    m_peak_raw_next    = peak_take ? avg_reg : raw_peak_reg;
                    m_tvalid_next      = 1'b1;
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            poll_elapsed_reg  <= '0;
            hold_elapsed_reg  <= '0;
            measuring_reg     <= 1'b0;
            sample_sum_reg    <= '0;
            samples_taken_reg <= '0;
            raw_peak_reg      <= '0;
            mapped_peak_reg   <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            poll_elapsed_reg  <= poll_elapsed_next;
            hold_elapsed_reg  <= hold_elapsed_next;
            measuring_reg     <= measuring_next;
            sample_sum_reg    <= sample_sum_next;
            samples_taken_reg <= samples_taken_next;
            raw_peak_reg      <= raw_peak_next;
            mapped_peak_reg   <= mapped_peak_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tick_reg       <= tick_next;
        valid_reg      <= valid_next;
        sample_reg     <= sample_next;
        avg_reg        <= avg_next;
        level_reg      <= level_next;
        m_level_reg    <= m_level_next;
        m_peak_mv_reg  <= m_peak_mv_next;
        m_peak_raw_reg <= m_peak_raw_next;
    end

    // The shared unit only takes a new job when it is free
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        u_req.start |-> !u_sts.busy)
        else $error("arith unit started while busy");

    // Outside a measurement no samples are pending
    a_idle_no_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        !measuring_reg |-> (samples_taken_reg == '0 && sample_sum_reg == '0))
        else $error("samples pending outside a measurement");

    // Committing a result fills the output slot
    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_tvalid_reg && !measuring_reg))
        else $error("result commit did not fill the output slot");

    // A decay step never raises the peak
    a_decay_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECAY && u_sts.done) |=> (raw_peak_reg <= $past(raw_peak_reg)))
        else $error("decay raised the raw peak");

endmodule

`default_nettype wire

// ----- sv/aphd_regs.sv -----
`default_nettype none

module aphd_regs
    import aphd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_ADC_FULL:    cfg_next.adc_full_count   = pwdata[CFG_W-1:0];
                REG_FULL_SCALE:  cfg_next.full_scale_mv    = pwdata[CFG_W-1:0];
                REG_POLL:        cfg_next.poll_interval_ms = pwdata[CFG_W-1:0];
                REG_HOLD:        cfg_next.hold_interval_ms = pwdata[CFG_W-1:0];
                REG_DECAY:       cfg_next.decay_factor     = pwdata[FACTOR_W-1:0];
                REG_AVG_COUNT:   cfg_next.average_count    = pwdata[AVG_W-1:0];
                REG_SLOPE:       cfg_next.slope_gain       = pwdata[CFG_W-1:0];
                REG_ZERO_OFFSET: cfg_next.zero_offset_mv   = pwdata[CFG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ADC_FULL:    prdata = APB_DATA_W'(cfg_reg.adc_full_count);
            REG_FULL_SCALE:  prdata = APB_DATA_W'(cfg_reg.full_scale_mv);
            REG_POLL:        prdata = APB_DATA_W'(cfg_reg.poll_interval_ms);
            REG_HOLD:        prdata = APB_DATA_W'(cfg_reg.hold_interval_ms);
            REG_DECAY:       prdata = APB_DATA_W'(cfg_reg.decay_factor);
            REG_AVG_COUNT:   prdata = APB_DATA_W'(cfg_reg.average_count);
            REG_SLOPE:       prdata = APB_DATA_W'(cfg_reg.slope_gain);
            REG_ZERO_OFFSET: prdata = APB_DATA_W'(cfg_reg.zero_offset_mv);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.adc_full_count   <= ADC_FULL_RST;
            cfg_reg.full_scale_mv    <= FULL_SCALE_RST;
            cfg_reg.poll_interval_ms <= POLL_RST;
            cfg_reg.hold_interval_ms <= HOLD_RST;
            cfg_reg.decay_factor     <= DECAY_RST;
            cfg_reg.average_count    <= AVG_COUNT_RST;
            cfg_reg.slope_gain       <= SLOPE_RST;
            cfg_reg.zero_offset_mv   <= ZERO_OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/aphd_arith_unit.sv -----
`default_nettype none

// Shared bit-serial multiply / restoring divide around one adder.
// Multiply: opa * opb, MSB of opb first, CFG_W steps.
// Divide: opa / opb, DIVN quotient bits, one per step.
module aphd_arith_unit
    import aphd_pkg::*;
#(
    parameter int W    = 44,
    parameter int DIVN = 28
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  unit_req_t             req,
    input  wire logic [W-1:0]     opa,
    input  wire logic [CFG_W-1:0] opb,
    output unit_sts_t             sts,
    output logic      [W-1:0]     result
);

    localparam int CNT_W = $clog2(DIVN + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    op_t              op_reg, op_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     shr_reg, shr_next;
    logic [W-1:0]     opd_reg, opd_next;

    logic             is_mul;
    logic [W-1:0]     add_x;
    logic [W-1:0]     add_y;
    logic [W:0]       add_sum;

    assign is_mul = (op_reg == OP_MUL);

    // One adder: add the multiplicand, or subtract the divisor as a trial
    always_comb begin
        if (is_mul) begin
            add_x = {acc_reg[W-2:0], 1'b0};
            add_y = shr_reg[W-1] ? opd_reg : '0;
        end else begin
            add_x = {acc_reg[W-2:0], shr_reg[W-1]};
            add_y = ~opd_reg;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + (W+1)'(!is_mul);
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        shr_next  = shr_reg;
        opd_next  = opd_reg;
        if (busy_reg) begin
            if (is_mul) begin
                acc_next = add_sum[W-1:0];
                shr_next = {shr_reg[W-2:0], 1'b0};
            end else begin
                acc_next = add_sum[W] ? add_sum[W-1:0] : add_x;
                shr_next = {shr_reg[W-2:0], add_sum[W]};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = '0;
            if (req.op == OP_MUL) begin
                opd_next = opa;
                shr_next = {opb, (W-CFG_W)'(0)};
                cnt_next = CNT_W'(CFG_W);
            end else begin
                opd_next = W'(opb);
                shr_next = opa << (W - DIVN);
                cnt_next = CNT_W'(DIVN);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        shr_reg <= shr_next;
        opd_reg <= opd_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = is_mul ? acc_reg : shr_reg;

endmodule

`default_nettype wire
